/* rtl/core/ddtr_pkg.sv */
// Shared types, constants and helpers for the differential-drive rollout block.
// Used by ddtr_ctrl, ddtr_dp and diff_drive_trajectory_rollout_top.
`default_nettype none
package ddtr_pkg;

    localparam int unsigned MAX_STEPS_DEF  = 64;
    localparam int unsigned CORDIC_ITER_DEF = 16;
    localparam int unsigned ATAN_ENTRIES   = 24;

    localparam logic [15:0] STEP_TIME_RST  = 16'd6554;
    localparam logic [6:0]  STEP_COUNT_RST = 7'd10;

    localparam logic [7:0]  REG_STEP_TIME  = 8'd0;
    localparam logic [7:0]  REG_STEP_COUNT = 8'd1;

    localparam logic signed [18:0] YAW_PI      = 19'sd25736;
    localparam logic signed [18:0] YAW_TWO_PI  = 19'sd51472;
    localparam logic signed [15:0] YAW_HALF_PI = 16'sd12868;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [15:0] start_yaw;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_yaw;
        logic               last_step;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FOLD,
        ST_GAIN,
        ST_ITER,
        ST_SAVE_LOCAL,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic setup;
        logic fold;
        logic src_step;
        logic gain;
        logic iter;
        logic save_local;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic iter_last;
        logic out_free;
        logic steps_last;
    } t_status;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:  r = 34'sh03243F6A8;
            5'd1:  r = 34'sh01DAC6705;
            5'd2:  r = 34'sh00FADBAFC;
            5'd3:  r = 34'sh007F56EA6;
            5'd4:  r = 34'sh003FEAB76;
            5'd5:  r = 34'sh001FFD55B;
            5'd6:  r = 34'sh000FFFAAA;
            5'd7:  r = 34'sh0007FFF55;
            5'd8:  r = 34'sh0003FFFEA;
            5'd9:  r = 34'sh0001FFFFD;
            5'd10: r = 34'sh0000FFFFF;
            5'd11: r = 34'sh00007FFFF;
            5'd12: r = 34'sh00003FFFF;
            5'd13: r = 34'sh00001FFFF;
            5'd14: r = 34'sh00000FFFF;
            5'd15: r = 34'sh000007FFF;
            5'd16: r = 34'sh000003FFF;
            5'd17: r = 34'sh000001FFF;
            5'd18: r = 34'sh000000FFF;
            5'd19: r = 34'sh0000007FF;
            5'd20: r = 34'sh0000003FF;
            5'd21: r = 34'sh0000001FF;
            5'd22: r = 34'sh0000000FF;
            5'd23: r = 34'sh00000007F;
            default: r = 34'sh0;
        endcase
        return r;
    endfunction

    // Two correction passes bring anything within +-3*pi into (-pi, pi].
    function automatic logic signed [15:0] wrap_yaw(input logic signed [18:0] a);
        logic signed [18:0] t;
        t = a;
        for (int k = 0; k < 2; k++) begin
            if (t > YAW_PI) t = t - YAW_TWO_PI;
            if (t <= -YAW_PI) t = t + YAW_TWO_PI;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sh007FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -37'sh0080000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ddtr_ctrl.sv */
// Sequencer for the rollout: setup, local CORDIC rotation, then one rotation per step.
// Depends on ddtr_pkg; drives ddtr_dp through t_cmd and reads t_status.
`default_nettype none
module ddtr_ctrl
    import ddtr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_state       o_state,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_phase_step, n_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase_step <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase_step <= n_phase_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase_step = r_phase_step;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state      = ST_SETUP;
                    n_phase_step = 1'b0;
                end
            end
            ST_SETUP: begin
                // no steps requested: drop the transaction
                if (i_status.n_zero) n_state = ST_IDLE;
                else n_state = ST_FOLD;
            end
            ST_FOLD:  n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_ITER;
            ST_ITER: begin
                if (i_status.iter_last) n_state = r_phase_step ? ST_UPDATE : ST_SAVE_LOCAL;
            end
            ST_SAVE_LOCAL: begin
                n_state      = ST_FOLD;
                n_phase_step = 1'b1;
            end
            ST_UPDATE: begin
                if (i_status.out_free) n_state = i_status.steps_last ? ST_IDLE : ST_FOLD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.src_step = r_phase_step;
        case (r_state)
            ST_IDLE:       o_cmd.load_item  = i_start;
            ST_SETUP:      o_cmd.setup      = 1'b1;
            ST_FOLD:       o_cmd.fold       = 1'b1;
            ST_GAIN:       o_cmd.gain       = 1'b1;
            ST_ITER:       o_cmd.iter       = 1'b1;
            ST_SAVE_LOCAL: o_cmd.save_local = 1'b1;
            ST_UPDATE:     o_cmd.update     = i_status.out_free;
            default:       o_cmd            = '0;
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

/* rtl/core/ddtr_dp.sv */
// Datapath: pose registers, shared CORDIC rotator and output register.
// Depends on ddtr_pkg; sequenced by ddtr_ctrl.
`default_nettype none
module ddtr_dp
    import ddtr_pkg::*;
#(
    parameter int unsigned MAX_STEPS   = MAX_STEPS_DEF,
    parameter int unsigned CORDIC_ITER = CORDIC_ITER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire t_in         i_in,
    input  wire logic [15:0] i_step_time,
    input  wire logic [6:0]  i_step_count,
    input  wire logic        i_out_stall,
    output t_status          o_status,
    output logic             o_out_valid,
    output t_out             o_out
);

    localparam int unsigned CW = $clog2(MAX_STEPS + 1);
    localparam int unsigned IW = $clog2(CORDIC_ITER);
    localparam int unsigned NI = (CORDIC_ITER < ATAN_ENTRIES) ? CORDIC_ITER : ATAN_ENTRIES;

    logic signed [31:0] r_run_x, r_run_y, r_local_dx, r_local_dy;
    logic signed [15:0] r_run_yaw, r_heading_step, r_v, r_w;
    logic [CW-1:0]      r_steps, r_n;
    logic [IW-1:0]      r_iter;
    logic signed [35:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [32:0] prod_v, prod_w, d_full;
    logic signed [18:0] a_full;
    logic signed [32:0] src_x, src_y, fx, fy;
    logic signed [15:0] ang, fa;
    logic signed [67:0] gx_p, gy_p;
    logic signed [35:0] xs, ys;
    logic signed [33:0] at;
    logic signed [36:0] sum_x, sum_y;
    logic signed [16:0] sum_yaw;
    logic [CW-1:0]      n_lim;
    logic               out_free;

    assign prod_v = r_v * $signed({1'b0, i_step_time});
    assign prod_w = r_w * $signed({1'b0, i_step_time});
    assign d_full = (prod_v + 33'sd2048) >>> 12;
    assign a_full = 19'((prod_w + 33'sd16384) >>> 15);

    assign n_lim = (32'(i_step_count) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(i_step_count);

    // fold angles beyond +-pi/2 with an exact quarter turn
    assign src_x = 33'(r_local_dx);
    assign src_y = 33'(r_local_dy);
    assign ang   = i_cmd.src_step ? r_run_yaw : r_heading_step;
    always_comb begin
        fx = src_x;
        fy = src_y;
        fa = ang;
        if (ang > YAW_HALF_PI) begin
            fx = -src_y;
            fy = src_x;
            fa = ang - YAW_HALF_PI;
        end else if (ang < -YAW_HALF_PI) begin
            fx = src_y;
            fy = -src_x;
            fa = ang + YAW_HALF_PI;
        end
    end

    // the folded vector still fits 33 bits when the gain is applied
    assign gx_p = $signed(r_cx[32:0]) * GAIN_Q30;
    assign gy_p = $signed(r_cy[32:0]) * GAIN_Q30;
    assign xs   = r_cx >>> r_iter;
    assign ys   = r_cy >>> r_iter;
    assign at   = atan_q30(5'(r_iter));

    assign sum_x   = 37'(r_run_x) + 37'(r_cx);
    assign sum_y   = 37'(r_run_y) + 37'(r_cy);
    assign sum_yaw = 17'(r_run_yaw) + 17'(r_heading_step);

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_run_x   <= i_in.start_x;
            r_run_y   <= i_in.start_y;
            r_run_yaw <= wrap_yaw(19'(i_in.start_yaw));
            r_v       <= i_in.linear_speed;
            r_w       <= i_in.angular_speed;
            r_n       <= n_lim;
        end
        if (i_cmd.setup) begin
            // local displacement starts as (d, 0) before its rotation
            r_local_dx     <= d_full[31:0];
            r_local_dy     <= '0;
            r_heading_step <= wrap_yaw(a_full);
        end
        if (i_cmd.fold) begin
            r_cx   <= 36'(fx);
            r_cy   <= 36'(fy);
            r_cz   <= 34'(fa) <<< 17;
            r_iter <= '0;
        end
        if (i_cmd.gain) begin
            r_cx <= 36'((gx_p + 68'sd536870912) >>> 30);
            r_cy <= 36'((gy_p + 68'sd536870912) >>> 30);
        end
        if (i_cmd.iter) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.save_local) begin
            r_local_dx <= sat32(37'(r_cx));
            r_local_dy <= sat32(37'(r_cy));
        end
        if (i_cmd.update) begin
            r_run_x          <= sat32(sum_x);
            r_run_y          <= sat32(sum_y);
            r_run_yaw        <= wrap_yaw(19'(sum_yaw));
            r_out.pose_x     <= sat32(sum_x);
            r_out.pose_y     <= sat32(sum_y);
            r_out.pose_yaw   <= wrap_yaw(19'(sum_yaw));
            r_out.last_step  <= (r_steps + 1'b1 == r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            if (i_cmd.update) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.load_item) r_steps <= '0;
            else if (i_cmd.update) r_steps <= r_steps + 1'b1;
        end
    end

    assign o_status.n_zero     = (r_n == '0);
    assign o_status.iter_last  = (32'(r_iter) == NI - 1);
    assign o_status.out_free   = out_free;
    assign o_status.steps_last = (r_steps + 1'b1 == r_n);
    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;

endmodule
`default_nettype wire

/* rtl/core/diff_drive_trajectory_rollout_top.sv */
// Rollout top level: one transaction in, one pose out per step, CORDIC rotations.
// Sequence: setup, then the local rotation (fold, gain, iterations, save local), then for each
// step fold, gain, iterations and an update that waits for a free output; the shared rotator sets this.
// A new transaction is taken only in idle: o_in_stall stays high until the last step is done.
// Reset (i_rst_n, synchronous, active low) returns to idle and restores step_time/step_count.
`default_nettype none
module diff_drive_trajectory_rollout_top
    import ddtr_pkg::*;
#(
    parameter int unsigned MAX_STEPS         = MAX_STEPS_DEF,
    parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_step_time;
    logic [6:0]  r_step_count;
    t_state      state;
    t_cmd        cmd;
    t_status     status;
    logic        start;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (state != ST_IDLE);
    assign start       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time  <= STEP_TIME_RST;
            r_step_count <= STEP_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_STEP_TIME) r_step_time <= i_cfg_data;
            else if (i_cfg_index == REG_STEP_COUNT) r_step_count <= i_cfg_data[6:0];
        end
    end

    ddtr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_state  (state),
        .o_cmd    (cmd)
    );

    ddtr_dp #(
        .MAX_STEPS   (MAX_STEPS),
        .CORDIC_ITER (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in         (i_in_data),
        .i_step_time  (r_step_time),
        .i_step_count (r_step_count),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_in_stall)
        else $error("input not blocked after accepting a transaction");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pose_yaw <= 16'sd25736 &&
                         o_out_data.pose_yaw > -16'sd25736))
        else $error("output yaw outside (-pi, pi]");

    a_update_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |-> (!o_out_valid || !i_out_stall))
        else $error("pose overwritten while a result still waits");

endmodule
`default_nettype wire
